>>> sv/pbes_pkg.sv
// Shared types and constants of the PCI bus enumeration sequencer.
`default_nettype none

package pbes_pkg;

  // Scan phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ID0   = 3'd1,
    PH_CLASS = 3'd2,
    PH_HDR   = 3'd3,
    PH_IDN   = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_REC  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RESP  = 1'b1;

  // Configuration space offsets
  localparam logic [7:0] OFF_IDENT = 8'h00;
  localparam logic [7:0] OFF_CLASS = 8'h08;
  localparam logic [7:0] OFF_HDR   = 8'h0C;
  localparam logic [7:0] OFF_MASK  = 8'hFC;

  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam int          HDR_MF_BIT  = 23;

  localparam int COUNT_W = 6;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    kind_t                kind;
    logic [31:0]          config_address;
    logic [7:0]           bus_number;
    logic [4:0]           slot_number;
    logic [2:0]           function_number;
    logic [15:0]          vendor;
    logic [15:0]          device;
    logic [7:0]           base_class;
    logic [7:0]           subclass_code;
    logic [7:0]           prog_interface;
    logic [COUNT_W-1:0]   found_count;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

>>> sv/pbes_rq.sv
// Result queue: up to two pushes per cycle, one pop per cycle.
`default_nettype none

module pbes_rq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    push_n,
  input  wire pbes_pkg::res_t d0,
  input  wire pbes_pkg::res_t d1,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pbes_pkg::res_t     out_data
);

  pbes_pkg::res_t mem [pbes_pkg::QDEPTH];

  logic [pbes_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pbes_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pbes_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // Hold off input unless two slots are free
  assign full      = (cnt_r > pbes_pkg::QCNT_W'(pbes_pkg::QDEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + pbes_pkg::QPTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + pbes_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + pbes_pkg::QCNT_W'(push_n) - pbes_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + pbes_pkg::QPTR_W'(1)] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/pci_bus_enumeration_sequencer.sv
// Top level of the PCI bus enumeration sequencer.
//
// Usage: drive a transaction with in_command = start to begin a scan; the block
// answers with a configuration read request (out_kind = request) carrying the
// type-1 address. Return each dword as a transaction with in_command = response
// and in_read_data. For every present function a device record follows the
// class read; the scan ends with a done transaction carrying the device count.
// A start at any time restarts the walk from bus 0, slot 0, function 0.
// Each result is written into the result queue and shows on the out_ ports once
// it reaches the head. Throughput: one input transaction per cycle while the
// receiver keeps up; a class response yields two results (record, then the next
// request or done), so the output side, one result per cycle, sets the pace then.
// A four-entry result queue separates the channels: input is taken while
// results wait, and in_stall rises only when fewer than two entries are free.
// Reset: the block goes idle with cleared counters and an empty queue;
// responses while idle or after done are dropped without a result.
// When the receiver stalls, the head result holds steady on the out_ ports.
`default_nettype none

module pci_bus_enumeration_sequencer #(
  parameter int MAX_DEVICES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [31:0] in_read_data,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_config_address,
  output logic [7:0]       out_bus_number,
  output logic [4:0]       out_slot_number,
  output logic [2:0]       out_function_number,
  output logic [15:0]      out_vendor,
  output logic [15:0]      out_device,
  output logic [7:0]       out_base_class,
  output logic [7:0]       out_subclass_code,
  output logic [7:0]       out_prog_interface,
  output logic [5:0]       out_found_count,
  output logic             out_last
);

  // Device counter must hold MAX_DEVICES itself
  localparam int CNT_W = $clog2(MAX_DEVICES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEVICES);

  // Scan state
  pbes_pkg::phase_t ph_r, ph_nxt;
  logic [7:0]       bus_r, bus_nxt;
  logic [4:0]       slot_r, slot_nxt;
  logic [2:0]       func_r, func_nxt;
  logic [31:0]      ident_r, ident_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  logic in_acc;
  logic q_full;

  // Next-slot move, shared by every path that leaves a slot
  pbes_pkg::phase_t ns_ph;
  logic [7:0]       ns_bus;
  logic [4:0]       ns_slot;
  logic             vendor_empty;

  // Results of this transaction
  logic [1:0]       push_n;
  pbes_pkg::res_t   r0, r1, fol, rec, head;
  logic [CNT_W+pbes_pkg::COUNT_W-1:0] cnt_ext;
  logic [7:0]       fol_off;

  assign in_acc       = in_valid && !in_stall;
  assign in_stall     = q_full;
  assign cnt_inc      = cnt_r + CNT_W'(1);
  assign vendor_empty = (in_read_data[15:0] == pbes_pkg::VENDOR_NONE);

  assign ns_slot = slot_r + 5'd1;
  assign ns_bus  = (slot_r == 5'd31) ? bus_r + 8'd1 : bus_r;
  assign ns_ph   = ((slot_r == 5'd31) && (bus_r == 8'd255)) ? pbes_pkg::PH_DONE
                                                            : pbes_pkg::PH_ID0;

  // Next state
  always_comb begin
    ph_nxt    = ph_r;
    bus_nxt   = bus_r;
    slot_nxt  = slot_r;
    func_nxt  = func_r;
    ident_nxt = ident_r;
    cnt_nxt   = cnt_r;
    if (in_acc) begin
      if (in_command == pbes_pkg::CMD_START) begin
        ph_nxt    = pbes_pkg::PH_ID0;
        bus_nxt   = '0;
        slot_nxt  = '0;
        func_nxt  = '0;
        ident_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        case (ph_r)
          pbes_pkg::PH_ID0, pbes_pkg::PH_IDN: begin
            if (vendor_empty) begin
              if ((ph_r == pbes_pkg::PH_ID0) || (func_r == 3'd7)) begin
                ph_nxt   = ns_ph;
                bus_nxt  = ns_bus;
                slot_nxt = ns_slot;
                func_nxt = '0;
              end else begin
                ph_nxt   = pbes_pkg::PH_IDN;
                func_nxt = func_r + 3'd1;
              end
            end else begin
              ident_nxt = in_read_data;
              ph_nxt    = pbes_pkg::PH_CLASS;
            end
          end
          pbes_pkg::PH_CLASS: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= MAX_CNT) begin
              ph_nxt = pbes_pkg::PH_DONE;
            end else if (func_r == 3'd0) begin
              ph_nxt = pbes_pkg::PH_HDR;
            end else if (func_r == 3'd7) begin
              ph_nxt   = ns_ph;
              bus_nxt  = ns_bus;
              slot_nxt = ns_slot;
              func_nxt = '0;
            end else begin
              ph_nxt   = pbes_pkg::PH_IDN;
              func_nxt = func_r + 3'd1;
            end
          end
          pbes_pkg::PH_HDR: begin
            if (in_read_data[pbes_pkg::HDR_MF_BIT]) begin
              // Multi-function device: probe function 1 next
              ph_nxt   = pbes_pkg::PH_IDN;
              func_nxt = 3'd1;
            end else begin
              ph_nxt   = ns_ph;
              bus_nxt  = ns_bus;
              slot_nxt = ns_slot;
              func_nxt = '0;
            end
          end
          default: begin
            ph_nxt = ph_r;
          end
        endcase
      end
    end
  end

  // Results: a follow-up (request or done) built from the next state,
  // and a device record built from the current state
  always_comb begin
    cnt_ext = {{pbes_pkg::COUNT_W{1'b0}}, cnt_nxt};

    case (ph_nxt)
      pbes_pkg::PH_CLASS: fol_off = pbes_pkg::OFF_CLASS;
      pbes_pkg::PH_HDR:   fol_off = pbes_pkg::OFF_HDR;
      default:            fol_off = pbes_pkg::OFF_IDENT;
    endcase

    fol             = '0;
    fol.found_count = cnt_ext[pbes_pkg::COUNT_W-1:0];
    fol.last        = 1'b1;
    if (ph_nxt == pbes_pkg::PH_DONE) begin
      fol.kind = pbes_pkg::KIND_DONE;
    end else begin
      fol.kind            = pbes_pkg::KIND_REQ;
      fol.config_address  = {1'b1, 7'd0, bus_nxt, slot_nxt, func_nxt,
                             fol_off & pbes_pkg::OFF_MASK};
      fol.bus_number      = bus_nxt;
      fol.slot_number     = slot_nxt;
      fol.function_number = func_nxt;
    end

    rec                 = '0;
    rec.kind            = pbes_pkg::KIND_REC;
    rec.bus_number      = bus_r;
    rec.slot_number     = slot_r;
    rec.function_number = func_r;
    rec.vendor          = ident_r[15:0];
    rec.device          = ident_r[31:16];
    rec.base_class      = in_read_data[31:24];
    rec.subclass_code   = in_read_data[23:16];
    rec.prog_interface  = in_read_data[15:8];
    rec.found_count     = cnt_ext[pbes_pkg::COUNT_W-1:0];
    rec.last            = 1'b0;

    push_n = 2'd0;
    r0     = fol;
    r1     = fol;
    if (in_acc) begin
      if (in_command == pbes_pkg::CMD_START) begin
        push_n = 2'd1;
      end else begin
        case (ph_r)
          pbes_pkg::PH_ID0, pbes_pkg::PH_IDN, pbes_pkg::PH_HDR: begin
            push_n = 2'd1;
          end
          pbes_pkg::PH_CLASS: begin
            push_n = 2'd2;
            r0     = rec;
          end
          default: begin
            push_n = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= pbes_pkg::PH_IDLE;
      bus_r   <= '0;
      slot_r  <= '0;
      func_r  <= '0;
      ident_r <= '0;
      cnt_r   <= '0;
    end else begin
      ph_r    <= ph_nxt;
      bus_r   <= bus_nxt;
      slot_r  <= slot_nxt;
      func_r  <= func_nxt;
      ident_r <= ident_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  pbes_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .d0        (r0),
    .d1        (r1),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign out_kind            = head.kind;
  assign out_config_address  = head.config_address;
  assign out_bus_number      = head.bus_number;
  assign out_slot_number     = head.slot_number;
  assign out_function_number = head.function_number;
  assign out_vendor          = head.vendor;
  assign out_device          = head.device;
  assign out_base_class      = head.base_class;
  assign out_subclass_code   = head.subclass_code;
  assign out_prog_interface  = head.prog_interface;
  assign out_found_count     = head.found_count;
  assign out_last            = head.last;

`ifndef SYNTHESIS
  // The count never passes the maximum
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("device count above maximum");

  // Idle is only left by a start, which clears the count
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == pbes_pkg::PH_IDLE) |-> (cnt_r == '0))
    else $error("count non-zero while idle");

  // The header read is only issued for function 0
  a_hdr_func0: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == pbes_pkg::PH_HDR) |-> (func_r == 3'd0))
    else $error("header phase on a higher function");

  // A class response leaves results waiting on the output
  a_class_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_command == pbes_pkg::CMD_RESP) && (ph_r == pbes_pkg::PH_CLASS))
      |=> out_valid)
    else $error("class response produced no output");
`endif

endmodule

`default_nettype wire

>>> test/pci_bus_enumeration_sequencer_tb.sv
// Self-checking testbench of the PCI bus enumeration sequencer.
`timescale 1ns / 100ps

module pci_bus_enumeration_sequencer_tb;

  // Device limit of the instance; the tracker closes a scan at the same count.
  localparam int DEVICE_LIMIT = 32;
  // Generous bound on the whole run: every transaction with its longest gap
  // and the longest receiver stalls.
  localparam int CYCLE_LIMIT  = 200000;
  // Random transactions that count towards the random part.
  localparam int RANDOM_ITEMS = 280;

  // Tracks the scan the block should be doing and holds the results it owes.
  class scan_tracker_t;
    pbes_pkg::phase_t phase;
    logic [7:0]       bus;
    logic [4:0]       slot;
    logic [2:0]       func;
    logic [31:0]      ident;
    int               found;
    pbes_pkg::res_t   awaited[$];
    int               faults;

    function new();
      phase  = pbes_pkg::PH_IDLE;
      bus    = '0;
      slot   = '0;
      func   = '0;
      ident  = '0;
      found  = 0;
      faults = 0;
    endfunction

    // Print one line per mismatch and count it.
    task report(string what);
      faults++;
      $display("[%0t] %s", $time, what);
    endtask

    function void emit_request(logic [7:0] offset);
      pbes_pkg::res_t r;
      r                 = '0;
      r.kind            = pbes_pkg::KIND_REQ;
      r.config_address  = {1'b1, 7'd0, bus, slot, func, offset & pbes_pkg::OFF_MASK};
      r.bus_number      = bus;
      r.slot_number     = slot;
      r.function_number = func;
      r.found_count     = found[pbes_pkg::COUNT_W-1:0];
      r.last            = 1'b1;
      awaited.push_back(r);
    endfunction

    function void emit_done();
      pbes_pkg::res_t r;
      r             = '0;
      r.kind        = pbes_pkg::KIND_DONE;
      r.found_count = found[pbes_pkg::COUNT_W-1:0];
      r.last        = 1'b1;
      awaited.push_back(r);
      phase = pbes_pkg::PH_DONE;
    endfunction

    // Function 0 of the next slot, or done after the last slot of the last bus.
    function void step_slot();
      func = '0;
      if (slot == 5'd31) begin
        slot = '0;
        if (bus == 8'd255) begin
          bus = '0;
          emit_done();
          return;
        end
        bus++;
      end else begin
        slot++;
      end
      phase = pbes_pkg::PH_ID0;
      emit_request(pbes_pkg::OFF_IDENT);
    endfunction

    function void step_func();
      if (func == 3'd7) begin
        step_slot();
        return;
      end
      func++;
      phase = pbes_pkg::PH_IDN;
      emit_request(pbes_pkg::OFF_IDENT);
    endfunction

    // Note an accepted input transaction and queue the results it causes.
    function void note_input(logic cmd, logic [31:0] data);
      pbes_pkg::res_t r;
      if (cmd == pbes_pkg::CMD_START) begin
        bus   = '0;
        slot  = '0;
        func  = '0;
        ident = '0;
        found = 0;
        phase = pbes_pkg::PH_ID0;
        emit_request(pbes_pkg::OFF_IDENT);
        return;
      end
      case (phase)
        pbes_pkg::PH_ID0, pbes_pkg::PH_IDN: begin
          if (data[15:0] == pbes_pkg::VENDOR_NONE) begin
            if (phase == pbes_pkg::PH_ID0) step_slot();
            else step_func();
          end else begin
            ident = data;
            phase = pbes_pkg::PH_CLASS;
            emit_request(pbes_pkg::OFF_CLASS);
          end
        end
        pbes_pkg::PH_CLASS: begin
          found++;
          r                 = '0;
          r.kind            = pbes_pkg::KIND_REC;
          r.bus_number      = bus;
          r.slot_number     = slot;
          r.function_number = func;
          r.vendor          = ident[15:0];
          r.device          = ident[31:16];
          r.base_class      = data[31:24];
          r.subclass_code   = data[23:16];
          r.prog_interface  = data[15:8];
          r.found_count     = found[pbes_pkg::COUNT_W-1:0];
          r.last            = 1'b0;
          awaited.push_back(r);
          if (found >= DEVICE_LIMIT) emit_done();
          else if (func == 3'd0) begin
            phase = pbes_pkg::PH_HDR;
            emit_request(pbes_pkg::OFF_HDR);
          end else begin
            step_func();
          end
        end
        pbes_pkg::PH_HDR: begin
          if (data[pbes_pkg::HDR_MF_BIT]) begin
            func = '0;
            step_func();
          end else begin
            step_slot();
          end
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    // Check one accepted result against the oldest one owed.
    task check_result(pbes_pkg::res_t got);
      pbes_pkg::res_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result kind %0d arrived with none owed", got.kind));
        return;
      end
      want = awaited.pop_front();
      compare("kind", got.kind, want.kind);
      compare("config_address", got.config_address, want.config_address);
      compare("bus_number", got.bus_number, want.bus_number);
      compare("slot_number", got.slot_number, want.slot_number);
      compare("function_number", got.function_number, want.function_number);
      compare("vendor", got.vendor, want.vendor);
      compare("device", got.device, want.device);
      compare("base_class", got.base_class, want.base_class);
      compare("subclass_code", got.subclass_code, want.subclass_code);
      compare("prog_interface", got.prog_interface, want.prog_interface);
      compare("found_count", got.found_count, want.found_count);
      compare("last", got.last, want.last);
    endtask
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        in_command   = pbes_pkg::CMD_START;
  logic [31:0] in_read_data = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_config_address;
  logic [7:0]  out_bus_number;
  logic [4:0]  out_slot_number;
  logic [2:0]  out_function_number;
  logic [15:0] out_vendor;
  logic [15:0] out_device;
  logic [7:0]  out_base_class;
  logic [7:0]  out_subclass_code;
  logic [7:0]  out_prog_interface;
  logic [5:0]  out_found_count;
  logic        out_last;

  scan_tracker_t  tracker = new();
  pbes_pkg::res_t seen;
  int             cycles     = 0;
  int             send_pct   = 0;  // chance of a sender gap before a transaction
  int             stall_pct  = 0;  // chance per cycle of a receiver stall burst
  int             stall_left = 0;
  int             items;

  pci_bus_enumeration_sequencer #(
    .MAX_DEVICES(DEVICE_LIMIT)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_read_data        (in_read_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_config_address  (out_config_address),
    .out_bus_number      (out_bus_number),
    .out_slot_number     (out_slot_number),
    .out_function_number (out_function_number),
    .out_vendor          (out_vendor),
    .out_device          (out_device),
    .out_base_class      (out_base_class),
    .out_subclass_code   (out_subclass_code),
    .out_prog_interface  (out_prog_interface),
    .out_found_count     (out_found_count),
    .out_last            (out_last)
  );

  always #5 clk = ~clk;

  // Receiver stalls: bursts started at random while enabled.
  // Exactly one assignment of out_stall per edge.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Capture each result transaction. Values read here are the ones that stood
  // before the edge, since the block and the stall driver update by NBA.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kind            = pbes_pkg::kind_t'(out_kind);
      seen.config_address  = out_config_address;
      seen.bus_number      = out_bus_number;
      seen.slot_number     = out_slot_number;
      seen.function_number = out_function_number;
      seen.vendor          = out_vendor;
      seen.device          = out_device;
      seen.base_class      = out_base_class;
      seen.subclass_code   = out_subclass_code;
      seen.prog_interface  = out_prog_interface;
      seen.found_count     = out_found_count;
      seen.last            = out_last;
      tracker.check_result(seen);
    end
  end

  // Watchdog: abandon a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, tracker.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one input transaction and hold it until accepted. Called right after
  // a rising edge; valid stays high into the next call unless a gap is drawn,
  // so it is assigned once per edge. Note the transaction at its accepting edge.
  task automatic push_item(input logic cmd, input logic [31:0] data);
    int gap;
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_read_data <= data;
    do @(posedge clk); while (!(in_valid && !in_stall));
    tracker.note_input(cmd, data);
  endtask

  // Answer the outstanding read with a well-formed dword. Presence and the
  // multi-function bit are drawn per mille; a class dword is fully random.
  task automatic answer(input int id0_pm, input int idn_pm, input int mf_pm);
    logic [31:0] word;
    word = $urandom;
    case (tracker.phase)
      pbes_pkg::PH_ID0, pbes_pkg::PH_IDN: begin
        if ($urandom_range(0, 999) >=
            ((tracker.phase == pbes_pkg::PH_ID0) ? id0_pm : idn_pm))
          word[15:0] = pbes_pkg::VENDOR_NONE;
        else if (word[15:0] == pbes_pkg::VENDOR_NONE)
          word[15:0] = 16'h0000;
      end
      pbes_pkg::PH_HDR: word[pbes_pkg::HDR_MF_BIT] = ($urandom_range(0, 999) < mf_pm);
      default: ;
    endcase
    push_item(pbes_pkg::CMD_RESP, word);
  endtask

  // Drain: drop valid and wait until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk, with light idling on both sides.
    send_pct  = 20;
    stall_pct = 20;
    push_item(pbes_pkg::CMD_RESP,  32'hFFFF_FFFF);  // response while idle: dropped
    push_item(pbes_pkg::CMD_START, 32'hFFFF_FFFF);  // read data ignored on a start
    push_item(pbes_pkg::CMD_RESP,  32'h0000_0000);  // slot 0 present, all-zero identity
    push_item(pbes_pkg::CMD_RESP,  32'hFFFF_FFFF);  // class all ones -> record, header
    push_item(pbes_pkg::CMD_RESP,  32'h0080_0000);  // multi-function -> function 1
    push_item(pbes_pkg::CMD_RESP,  32'hFFFF_FFFF);  // function 1 empty -> function 2
    push_item(pbes_pkg::CMD_RESP,  32'hFFFF_0000);  // function 2 present
    push_item(pbes_pkg::CMD_RESP,  32'h0000_0000);  // record, then function 3
    repeat (5) push_item(pbes_pkg::CMD_RESP, 32'h5A5A_FFFF);  // functions 3..7 empty
    push_item(pbes_pkg::CMD_RESP,  32'h0000_FFFF);  // slot 1 empty -> slot 2
    push_item(pbes_pkg::CMD_RESP,  32'hA5A5_5A5A);  // slot 2 present
    push_item(pbes_pkg::CMD_RESP,  32'h0C03_3000);  // record, header read
    push_item(pbes_pkg::CMD_RESP,  32'hFF7F_FFFF);  // single function -> slot 3
    push_item(pbes_pkg::CMD_START, 32'h0000_0000);  // restart mid-scan
    push_item(pbes_pkg::CMD_RESP,  32'hFFFE_FFFE);  // present
    push_item(pbes_pkg::CMD_START, 32'h1234_5678);  // restart while the class read waits
    push_item(pbes_pkg::CMD_RESP,  32'hFFFF_FFFF);  // slot 0 empty -> slot 1

    // Hold the sender until the block has delivered everything it owes.
    drain();
    repeat (4) @(posedge clk);

    // Random scans: mostly well-formed answers, some restarts and raw noise.
    // Ignored responses while idle or done do not count.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (items % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: send_pct = 0;
          1: send_pct = 12;
          default: send_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (tracker.phase == pbes_pkg::PH_IDLE || tracker.phase == pbes_pkg::PH_DONE) begin
        if ($urandom_range(0, 99) < 25) begin
          push_item(pbes_pkg::CMD_RESP, $urandom);
        end else begin
          push_item(pbes_pkg::CMD_START, $urandom);
          items++;
        end
      end else begin
        case ($urandom_range(0, 99))
          0, 1, 2:    push_item(pbes_pkg::CMD_START, $urandom);
          3, 4, 5, 6: push_item(pbes_pkg::CMD_RESP, $urandom);
          default:    answer(450, 500, 400);
        endcase
        items++;
      end
    end

    // Last part, no idling: a densely populated scan that ends when the
    // device limit is reached.
    send_pct  = 0;
    stall_pct = 0;
    drain();
    do @(posedge clk); while (stall_left != 0 || out_stall);
    push_item(pbes_pkg::CMD_START, 32'h0000_0000);
    while (tracker.phase != pbes_pkg::PH_DONE) answer(900, 500, 500);
    push_item(pbes_pkg::CMD_RESP, 32'h0000_0000);  // after done: dropped
    push_item(pbes_pkg::CMD_RESP, 32'hFFFF_FFFF);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
